>>> design/indentation_block_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef INDENTATION_BLOCK_TOKENIZER_ASSERT_SVH
`define INDENTATION_BLOCK_TOKENIZER_ASSERT_SVH

// Check that holds in the same cycle as its trigger.
`define IBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after its trigger.
`define IBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ibt_pkg.sv
package ibt_pkg;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned LEVEL_W = 9;
  localparam int unsigned NEST_W  = 8;

  typedef enum logic [2:0] {
    CLS_OTHER     = 3'd0,
    CLS_OPEN_PAR  = 3'd1,
    CLS_CLOSE_PAR = 3'd2,
    CLS_OPEN_BRK  = 3'd3,
    CLS_CLOSE_BRK = 3'd4,
    CLS_NEWLINE   = 3'd5,
    CLS_SPACE     = 3'd6,
    CLS_END       = 3'd7
  } cls_t;

  typedef enum logic [2:0] {
    KIND_TOKEN = 3'd0,
    KIND_START = 3'd1,
    KIND_END   = 3'd2,
    KIND_SEP   = 3'd3,
    KIND_EOS   = 3'd4,
    KIND_ERROR = 3'd5
  } kind_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

>>> design/ibt_cmp.sv
module ibt_cmp (
  input  logic signed [ibt_pkg::LEVEL_W-1:0] a,
  input  logic signed [ibt_pkg::LEVEL_W-1:0] b,
  output ibt_pkg::cmp_res_t                  res
);
  import ibt_pkg::*;

  // Signed compare of two indentation levels; minus one marks no level.
  assign res.lt = (a < b);
  assign res.eq = (a == b);
  assign res.gt = (a > b);

endmodule

>>> design/ibt_stack.sv
module ibt_stack #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [ibt_pkg::LEN_W-1:0]  wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [ibt_pkg::LEN_W-1:0]  rd_data
);
  import ibt_pkg::*;

  logic [LEN_W-1:0] mem_r [DEPTH];
  logic [LEN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/indentation_block_tokenizer.sv
// Flow: a token in an open line goes straight to the token state; the first token of a line
// first passes the level check (S_CMP); a dedent then reads (S_RD) and compares (S_POP) each level popped.
// Newline and whitespace words are taken in idle; end of input emits one END per open level, then EOS.
// The sequencer handles one word at a time and writes its results one by one into the output
// register, each only while the output slot is free; each stack level is read (S_RD) before its compare (S_POP).
// Reset (rst_n low, synchronous) empties the stack and clears the nesting and line state.
module indentation_block_tokenizer #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // token_code [15:0], space_length [23:16]
  input  logic [2:0]  in_tuser,   // token_class [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_code [15:0]
  output logic [2:0]  out_tuser,  // out_kind [2:0]
  output logic        out_tlast
);
  import ibt_pkg::*;

  `include "indentation_block_tokenizer_assert.svh"

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RD,
    S_POP,
    S_TOKEN,
    S_FLUSH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              stack_cnt_r, stack_cnt_nxt;
  logic signed [LEVEL_W-1:0]  last_ind_r, last_ind_nxt;
  logic [NEST_W-1:0]          paren_r, paren_nxt;
  logic [NEST_W-1:0]          bracket_r, bracket_nxt;
  logic                       line_open_r, line_open_nxt;
  logic [LEN_W-1:0]           pend_r, pend_nxt;
  logic                       seen_r, seen_nxt;
  logic [CODE_W-1:0]          code_r, code_nxt;
  logic                       out_valid_r, out_valid_nxt;
  kind_t                      out_kind_r, out_kind_nxt;
  logic [CODE_W-1:0]          out_code_r, out_code_nxt;
  logic                       out_last_r, out_last_nxt;

  cls_t                       in_cls;
  logic [CODE_W-1:0]          in_code;
  logic [LEN_W-1:0]           in_len;
  logic                       slot_free;
  logic signed [LEVEL_W-1:0]  ind;
  logic signed [LEVEL_W-1:0]  cmp_a, cmp_b;
  cmp_res_t                   cmp;
  logic [CW-1:0]              cnt_m1;
  logic                       wr_en;
  logic [LEN_W-1:0]           top;
  logic                       emit;
  kind_t                      emit_kind;
  logic [CODE_W-1:0]          emit_code;
  logic                       emit_last;

  assign in_cls    = cls_t'(in_tuser);
  assign in_code   = in_tdata[15:0];
  assign in_len    = in_tdata[23:16];
  assign in_tready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_tready;
  assign ind       = seen_r ? $signed({1'b0, pend_r}) : '0;
  assign cnt_m1    = stack_cnt_r - CW'(1);

  // The one comparator serves both the level check and each step of the pop loop.
  assign cmp_a = (state_r == S_POP) ? $signed({1'b0, top}) : ind;
  assign cmp_b = (state_r == S_POP) ? ind : last_ind_r;

  ibt_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  ibt_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stack_cnt_r[AW-1:0]),
    .wr_data (pend_r),
    .rd_addr (cnt_m1[AW-1:0]),
    .rd_data (top)
  );

  always_comb begin
    state_nxt     = state_r;
    stack_cnt_nxt = stack_cnt_r;
    last_ind_nxt  = last_ind_r;
    paren_nxt     = paren_r;
    bracket_nxt   = bracket_r;
    line_open_nxt = line_open_r;
    pend_nxt      = pend_r;
    seen_nxt      = seen_r;
    code_nxt      = code_r;
    wr_en         = 1'b0;
    emit          = 1'b0;
    emit_kind     = KIND_TOKEN;
    emit_code     = '0;
    emit_last     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_cls)
            CLS_END: begin
              state_nxt = S_FLUSH;
            end
            CLS_NEWLINE: begin
              if (!(line_open_r && (paren_r != '0 || bracket_r != '0))) begin
                line_open_nxt = 1'b0;
                seen_nxt      = 1'b0;
                pend_nxt      = '0;
                paren_nxt     = '0;
                bracket_nxt   = '0;
              end
            end
            CLS_SPACE: begin
              if (!line_open_r && !seen_r) begin
                pend_nxt = in_len;
                seen_nxt = 1'b1;
              end
            end
            default: begin
              if (in_cls == CLS_OPEN_PAR && paren_r != '1) begin
                paren_nxt = paren_r + NEST_W'(1);
              end
              if (in_cls == CLS_CLOSE_PAR && paren_r != '0) begin
                paren_nxt = paren_r - NEST_W'(1);
              end
              if (in_cls == CLS_OPEN_BRK && bracket_r != '1) begin
                bracket_nxt = bracket_r + NEST_W'(1);
              end
              if (in_cls == CLS_CLOSE_BRK && bracket_r != '0) begin
                bracket_nxt = bracket_r - NEST_W'(1);
              end
              code_nxt      = in_code;
              line_open_nxt = 1'b1;
              state_nxt     = line_open_r ? S_TOKEN : S_CMP;
            end
          endcase
        end
      end
      S_CMP: begin
        if (slot_free) begin
          priority if (cmp.eq) begin
            emit      = 1'b1;
            emit_kind = KIND_SEP;
            state_nxt = S_TOKEN;
          end else if (cmp.gt) begin
            emit      = 1'b1;
            state_nxt = S_TOKEN;
            if (stack_cnt_r < CW'(STACK_DEPTH)) begin
              wr_en         = 1'b1;
              stack_cnt_nxt = stack_cnt_r + CW'(1);
              last_ind_nxt  = ind;
              emit_kind     = KIND_START;
            end else begin
              emit_kind = KIND_ERROR;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        // With levels left, this cycle reads the top entry for the next state.
        if (stack_cnt_r == '0) begin
          if (slot_free) begin
            emit         = 1'b1;
            emit_kind    = KIND_ERROR;
            last_ind_nxt = '1;
            state_nxt    = S_TOKEN;
          end
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (slot_free) begin
          emit = 1'b1;
          priority if (cmp.gt) begin
            emit_kind     = KIND_END;
            stack_cnt_nxt = cnt_m1;
            state_nxt     = S_RD;
          end else if (cmp.eq) begin
            emit_kind    = KIND_SEP;
            last_ind_nxt = ind;
            state_nxt    = S_TOKEN;
          end else begin
            emit_kind    = KIND_ERROR;
            last_ind_nxt = $signed({1'b0, top});
            state_nxt    = S_TOKEN;
          end
        end
      end
      S_TOKEN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = KIND_TOKEN;
          emit_code = code_r;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          emit = 1'b1;
          if (stack_cnt_r != '0) begin
            emit_kind     = KIND_END;
            stack_cnt_nxt = cnt_m1;
          end else begin
            emit_kind     = KIND_EOS;
            emit_last     = 1'b1;
            last_ind_nxt  = '1;
            line_open_nxt = 1'b0;
            seen_nxt      = 1'b0;
            pend_nxt      = '0;
            paren_nxt     = '0;
            bracket_nxt   = '0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_kind_nxt  = emit ? emit_kind : out_kind_r;
    out_code_nxt  = emit ? emit_code : out_code_r;
    out_last_nxt  = emit ? emit_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stack_cnt_r <= '0;
      last_ind_r  <= '1;
      paren_r     <= '0;
      bracket_r   <= '0;
      line_open_r <= 1'b0;
      pend_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stack_cnt_r <= stack_cnt_nxt;
      last_ind_r  <= last_ind_nxt;
      paren_r     <= paren_nxt;
      bracket_r   <= bracket_nxt;
      line_open_r <= line_open_nxt;
      pend_r      <= pend_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r     <= code_nxt;
    out_kind_r <= out_kind_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `IBT_ASSERT_NOW(a_cnt_bound, 1'b1, stack_cnt_r <= CW'(STACK_DEPTH), "count over depth")
  `IBT_ASSERT_NOW(a_mid_run_busy, out_valid_r && !out_last_r, state_r != S_IDLE, "idle mid-run")
  `IBT_ASSERT_NEXT(a_end_pops, emit && emit_kind == KIND_END, stack_cnt_r == $past(cnt_m1), "no pop")
  `IBT_ASSERT_NEXT(a_eos_clears, emit && emit_kind == KIND_EOS, &last_ind_r && stack_cnt_r == '0, "eos")

endmodule
